// ===== design/csrmv_pkg.sv =====
// shared types and constants for the sparse row-product unit
package csrmv_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
  localparam int OP_W         = 2;
  localparam int COL_W        = 10;
  localparam int VAL_W        = 32;
  localparam int ROW_W        = 16;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int SHP_W        = PROD_W - FRAC_W;
  localparam int SUM_W        = SHP_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_MAC  = 2'd1,
    OP_END  = 2'd2
  } op_t;

  // word held between the read stage and the multiply stage
  typedef struct packed {
    logic                    vld;
    op_t                     op;
    logic                    zero;
    logic signed [VAL_W-1:0] val;
  } stage_t;

  // finished row handed to the output register
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] sum;
    logic [ROW_W-1:0]        row;
    logic                    sat;
  } result_t;

endpackage

// ===== design/csrmv_vec_mem.sv =====
// dense vector store: one write port, one registered read port
module csrmv_vec_mem
  import csrmv_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [VEC_AW-1:0] waddr,
  input  logic [VAL_W-1:0]  wdata,
  input  logic              re,
  input  logic [VEC_AW-1:0] raddr,
  output logic [VAL_W-1:0]  rdata
);

  logic [VAL_W-1:0] mem [VECTOR_DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/csrmv_mac.sv =====
// multiply stage and row accumulator with saturation and row count
module csrmv_mac
  import csrmv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  stage_t           s1_i,
  input  logic [VAL_W-1:0] rd_data,
  output result_t          res_o
);

  logic                     s2_vld_r;
  op_t                      s2_op_r;
  logic signed [SHP_W-1:0]  s2_prod_r;
  logic signed [VAL_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  acc_nxt;
  logic                     sat_r;
  logic                     sat_nxt;
  logic [ROW_W-1:0]         row_r;
  logic [ROW_W-1:0]         row_nxt;
  logic signed [VAL_W-1:0]  x_op;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [SUM_W-1:0]  sum;
  logic                     ovf;
  logic                     s2_mac;
  logic                     s2_end;

  // one signed 32x32 multiply, product floored by 2^16 into the stage register
  assign x_op      = s1_i.zero ? '0 : $signed(rd_data);
  assign prod_full = $signed(s1_i.val) * x_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r <= s1_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op_r   <= s1_i.op;
      s2_prod_r <= prod_full[PROD_W-1:FRAC_W];
    end
  end

  assign s2_mac = s2_vld_r && (s2_op_r == OP_MAC);
  assign s2_end = s2_vld_r && (s2_op_r == OP_END);

  // exact sum, then clamp to the signed word range
  assign sum = SUM_W'(acc_r) + SUM_W'(s2_prod_r);
  assign ovf = (sum[SUM_W-1:VAL_W-1] != '0) && (sum[SUM_W-1:VAL_W-1] != '1);

  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    row_nxt = row_r;
    if (advance && s2_mac) begin
      sat_nxt = sat_r | ovf;
      if (ovf) begin
        acc_nxt = sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        acc_nxt = sum[VAL_W-1:0];
      end
    end else if (advance && s2_end) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
      row_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
      row_r <= row_nxt;
    end
  end

  assign res_o.vld = s2_end;
  assign res_o.sum = acc_r;
  assign res_o.row = row_r;
  assign res_o.sat = sat_r;

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_end) |=> (acc_r == '0) && !sat_r)
    else $error("accumulator not cleared after end of row");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_end) |=> (row_r == ROW_W'($past(row_r) + ROW_W'(1))))
    else $error("row number did not step by one");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && !(advance && s2_end)) |=> sat_r)
    else $error("saturation flag dropped inside a row");

endmodule

// ===== design/sparse_csr_matrix_vector_product_unit.sv =====
// top level of the compressed-row sparse matrix times dense vector unit
//
// Words stream in one per clock unless stalled: a load word (opcode 0) writes
// one element of the dense vector into a 1024 x 32 store, a nonzero word
// (opcode 1) reads the element at its column and adds value * element (signed
// Q16.16, product floored by 2^16, sum clamped to 32 bits) into the row
// accumulator, and an end-row word (opcode 2) gives one result word with the
// row sum, the row number and a flag set if any addition of that row clamped.
// Opcode 3 does nothing. The unit takes one word every clock unless stalled;
// the figure is set by the single read port of the vector store and the one
// multiply-accumulate stage, which closes its loop through the accumulator. A
// result word passes the read, multiply and output registers. While a result
// waits in the output register with out_stall high, in_stall is high and the
// whole pipe holds. The store has no reset and no clearing pass: an element
// must be loaded before a nonzero reads it. A load and a later nonzero at the
// same column never meet in the store in one cycle, so no forwarding is needed.
module sparse_csr_matrix_vector_product_unit
  import csrmv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [COL_W-1:0]        in_column_index,
  input  logic signed [VAL_W-1:0] in_operand_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_row_sum,
  output logic [ROW_W-1:0]        out_row_number,
  output logic                    out_sum_saturated
);

  logic                    advance;
  logic                    accept;
  logic                    is_load;
  logic                    is_mac;
  logic                    is_end;
  logic                    col_ok;
  logic [VEC_AW-1:0]       vec_addr;
  logic [VAL_W-1:0]        rd_data;
  stage_t                  s1_r;
  stage_t                  s1_nxt;
  result_t                 res;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_sum_r;
  logic [ROW_W-1:0]        out_row_r;
  logic                    out_sat_r;

  // the pipe moves unless a finished row is stuck in the output register
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // opcode decode
  always_comb begin
    is_load = 1'b0;
    is_mac  = 1'b0;
    is_end  = 1'b0;
    unique case (op_t'(in_opcode))
      OP_LOAD: is_load = 1'b1;
      OP_MAC:  is_mac  = 1'b1;
      OP_END:  is_end  = 1'b1;
      default: ;
    endcase
  end

  // columns past the store depth: loads dropped, nonzeros read zero
  assign col_ok   = 32'(in_column_index) < 32'(VECTOR_DEPTH);
  assign vec_addr = VEC_AW'(in_column_index);

  csrmv_vec_mem u_vec_mem (
    .clk   (clk),
    .we    (accept && is_load && col_ok),
    .waddr (vec_addr),
    .wdata (in_operand_value),
    .re    (advance),
    .raddr (vec_addr),
    .rdata (rd_data)
  );

  // read stage: word waits here for the store's read data
  always_comb begin
    s1_nxt      = s1_r;
    s1_nxt.vld  = accept && (is_mac || is_end);
    s1_nxt.op   = op_t'(in_opcode);
    s1_nxt.zero = !col_ok;
    s1_nxt.val  = in_operand_value;
  end

  // only the valid bit is reset, the payload just follows the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (advance) begin
      s1_r.vld <= s1_nxt.vld;
    end
    if (advance) begin
      s1_r.op   <= s1_nxt.op;
      s1_r.zero <= s1_nxt.zero;
      s1_r.val  <= s1_nxt.val;
    end
  end

  csrmv_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .s1_i    (s1_r),
    .rd_data (rd_data),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_sum_r <= res.sum;
      out_row_r <= res.row;
      out_sat_r <= res.sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_sum       = out_sum_r;
  assign out_row_number    = out_row_r;
  assign out_sum_saturated = out_sat_r;

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(s1_r.vld) && $stable(out_valid_r))
    else $error("pipe moved while the output was held");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("word taken while a result was held");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_sum_r)
      && $stable(out_row_r) && $stable(out_sat_r))
    else $error("held result word changed");

endmodule
